// ===== sv/bct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_SECONDS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ADJUST_STEP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UPPER_LIMIT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MS_PER_TICK     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MS_PER_SECOND   = 3'd4;

  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MsW      = 10;
  localparam int unsigned AccW     = 11;

  // Reset values of the registers
  localparam logic [CountW-1:0] INITIAL_SECONDS_RST = 8'd30;
  localparam logic [CountW-1:0] ADJUST_STEP_RST     = 8'd5;
  localparam logic [CountW-1:0] UPPER_LIMIT_RST     = 8'd250;
  localparam logic [MsW-1:0]    MS_PER_TICK_RST     = 10'd32;
  localparam logic [MsW-1:0]    MS_PER_SECOND_RST   = 10'd1000;

  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;
  localparam logic [AccW-1:0]   ACC_MAX   = 11'd2047;

  // Live settings handed to the update logic
  typedef struct packed {
    logic [CountW-1:0] adjust_step;
    logic [CountW-1:0] upper_limit;
    logic [MsW-1:0]    ms_per_tick;
    logic [MsW-1:0]    ms_per_second;
  } bct_cfg_t;

  // One sample of the buttons and the tick
  typedef struct packed {
    logic tick;
    logic button_down;
    logic button_up;
    logic button_stop;
    logic button_start;
  } bct_item_t;

  // One result word
  typedef struct packed {
    logic              running;
    logic              alarm;
    logic [CountW-1:0] port_seconds;
    logic [CountW-1:0] seconds_left;
  } bct_result_t;

endpackage

`default_nettype wire

// ===== sv/bct_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bct_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bct_pkg::CfgDataW-1:0]  cfg_data_i,
  output bct_pkg::bct_cfg_t                  cfg_o
);

  bct_pkg::bct_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // Decode a write; initial_seconds only matters at reset, where it is
  // back at its reset value, so a write to it changes nothing
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bct_pkg::REG_INITIAL_SECONDS: ;
        bct_pkg::REG_ADJUST_STEP:   cfg_d.adjust_step   = cfg_data_i[bct_pkg::CountW-1:0];
        bct_pkg::REG_UPPER_LIMIT:   cfg_d.upper_limit   = cfg_data_i[bct_pkg::CountW-1:0];
        bct_pkg::REG_MS_PER_TICK:   cfg_d.ms_per_tick   = cfg_data_i[bct_pkg::MsW-1:0];
        bct_pkg::REG_MS_PER_SECOND: cfg_d.ms_per_second = cfg_data_i[bct_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adjust_step   <= bct_pkg::ADJUST_STEP_RST;
      cfg_q.upper_limit   <= bct_pkg::UPPER_LIMIT_RST;
      cfg_q.ms_per_tick   <= bct_pkg::MS_PER_TICK_RST;
      cfg_q.ms_per_second <= bct_pkg::MS_PER_SECOND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/bct_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bct_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire bct_pkg::bct_item_t item_i,
  input  wire bct_pkg::bct_cfg_t  cfg_i,
  output bct_pkg::bct_result_t    result_o
);

  logic [3:0]                   prev_q, prev_d;
  logic                         run_q, run_d;
  logic [bct_pkg::AccW-1:0]     acc_q, acc_d;
  logic [bct_pkg::CountW-1:0]   count_q, count_d;
  logic [bct_pkg::CountW-1:0]   port_q, port_d;
  logic                         alarm_q, alarm_d;

  logic [3:0]                   now;
  logic [3:0]                   rise;
  logic [bct_pkg::CountW:0]     up_sum;
  logic [bct_pkg::CountW-1:0]   cnt_up;
  logic [bct_pkg::AccW:0]       acc_sum;
  logic [bct_pkg::AccW-1:0]     acc_tick;
  logic [bct_pkg::AccW-1:0]     mps;

  assign now  = {item_i.button_down, item_i.button_up, item_i.button_stop,
                 item_i.button_start};
  assign rise = now & ~prev_q;
  assign mps  = {1'b0, cfg_i.ms_per_second};

  // Button edges, tick accumulation and the one-second boundary
  always_comb begin
    prev_d = now;

    // start, then stop
    run_d = rise[0] ? 1'b1 : run_q;
    if (rise[1]) run_d = 1'b0;

    // up press, only below upper_limit, saturating at the top of the count
    up_sum = {1'b0, count_q} + {1'b0, cfg_i.adjust_step};
    cnt_up = count_q;
    if (rise[2] && (count_q < cfg_i.upper_limit)) begin
      cnt_up = up_sum[bct_pkg::CountW] ? bct_pkg::COUNT_MAX
                                       : up_sum[bct_pkg::CountW-1:0];
    end

    // down press, saturating at zero
    count_d = cnt_up;
    if (rise[3]) begin
      count_d = (cnt_up > cfg_i.adjust_step) ? cnt_up - cfg_i.adjust_step
                                             : '0;
    end

    // tick adds its milliseconds while running
    acc_tick = rise[1] ? '0 : acc_q;
    acc_sum  = {1'b0, acc_tick} + {2'b00, cfg_i.ms_per_tick};
    if (run_d && item_i.tick) begin
      acc_tick = acc_sum[bct_pkg::AccW] ? bct_pkg::ACC_MAX
                                        : acc_sum[bct_pkg::AccW-1:0];
    end

    // second boundary
    acc_d   = acc_tick;
    port_d  = port_q;
    alarm_d = alarm_q;
    if (acc_tick >= mps) begin
      if ((count_d != '0) && run_d) count_d = count_d - 1'b1;
      if (count_d == '0) alarm_d = 1'b1;
      port_d = count_d;
      acc_d  = acc_tick - mps;
    end

    result_o.seconds_left = count_d;
    result_o.port_seconds = port_d;
    result_o.alarm        = alarm_d;
    result_o.running      = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      run_q   <= 1'b0;
      acc_q   <= '0;
      count_q <= bct_pkg::INITIAL_SECONDS_RST;
      port_q  <= '0;
      alarm_q <= 1'b0;
    end else if (step_i) begin
      prev_q  <= prev_d;
      run_q   <= run_d;
      acc_q   <= acc_d;
      count_q <= count_d;
      port_q  <= port_d;
      alarm_q <= alarm_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/button_countdown_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Countdown timer driven by four push buttons and a periodic tick. Each input
// word is one sample of the buttons and the tick; only rising button edges
// act (start, stop, up, down, in that order), then the tick adds to the
// millisecond accumulator and at most one second boundary is taken. Every
// input word yields exactly one result word with the state after the update.
// The block takes one word per clock while the sink does not stall; a word
// passes through one input register, then the update logic into the result
// register, which also holds a result while the sink stalls. The count
// resets to 30; a write to initial_seconds does not reload it. The user must
// write configuration only while no word is in flight; it is not enforced.
module button_countdown_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // stream in
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] button_start, [1] button_stop, [2] button_up, [3] button_down,
  // [4] tick, [7:5] zero
  input  wire logic [7:0]                    s_axis_tdata,
  // stream out
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] seconds_left, [15:8] port_seconds, [16] alarm, [17] running,
  // [23:18] zero
  output logic [23:0]                        m_axis_tdata,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bct_pkg::CfgDataW-1:0]  cfg_data_i
);

  bct_pkg::bct_cfg_t    cfg;
  bct_pkg::bct_item_t   in_q;
  bct_pkg::bct_result_t result, out_q;
  logic                 in_valid_q, out_valid_q;
  logic                 advance;

  // Word moves from the input register into the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  bct_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bct_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[4:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

`default_nettype wire
